/* hdl/flvd_pkg.sv */
// Shared types and constants for the FLV tag deframer.
// Depends on nothing; imported by flv_tag_deframer_unit.
package flvd_pkg;

    typedef enum logic [1:0] {
        PH_FILE_HDR = 2'd0,
        PH_SKIP     = 2'd1,
        PH_TAG_HDR  = 2'd2,
        PH_PAYLOAD  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FILE_HDR   = 2'd0,
        KIND_TAG_HDR    = 2'd1,
        KIND_PAYLOAD    = 2'd2,
        KIND_LAST_BYTE  = 2'd3
    } t_kind;

    localparam logic [3:0] FILE_HDR_LAST = 4'd8;   // 9-byte file header
    localparam logic [3:0] SKIP_LAST     = 4'd3;   // 4-byte previous-tag-size
    localparam logic [3:0] TAG_HDR_LAST  = 4'd10;  // 11-byte tag header
    localparam logic [3:0] FLAGS_POS     = 4'd4;   // flags byte of file header

    localparam logic [7:0] TYPE_AUDIO  = 8'd8;
    localparam logic [7:0] TYPE_VIDEO  = 8'd9;
    localparam logic [7:0] TYPE_SCRIPT = 8'd18;

endpackage

/* hdl/flv_tag_deframer_unit.sv */
// FLV tag deframer top level: byte-wide file parser with tag records.
// Depends on flvd_pkg (phase and kind types, header lengths, tag types).
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_stall | i_data_byte, i_first_byte
//  result  | o_valid | i_stall | o_kind, flags, tag fields, o_payload_byte,
//          |         |         | o_tag_total .. o_script_tags
//
// One byte per cycle while o_stall is low: the parse state updates in the cycle
// a byte is accepted and any result lands in the output register at the same
// edge. Reset (synchronous, active low) returns to the file header phase
// with all counters and tag fields cleared. A held result stalls input only
// while the downstream side stalls it; a result taken in the same cycle frees
// the register for the next one.
module flv_tag_deframer_unit
    import flvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_has_audio,
    output logic        o_has_video,
    output logic [7:0]  o_tag_code,
    output logic [23:0] o_payload_size,
    output logic [31:0] o_timestamp,
    output logic [23:0] o_stream_num,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_tag_total,
    output logic [15:0] o_audio_tags,
    output logic [15:0] o_video_tags,
    output logic [15:0] o_script_tags
);

    // Parse state
    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [1:0]  r_flags, n_flags;       // {audio, video}
    logic [23:0] r_remain, n_remain;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_size, n_size;
    logic [31:0] r_time, n_time;
    logic [23:0] r_stream, n_stream;
    logic [15:0] r_total, n_total;
    logic [15:0] r_audio, n_audio;
    logic [15:0] r_video, n_video;
    logic [15:0] r_script, n_script;

    // Result register
    logic        r_out_valid;
    t_kind       r_kind;
    logic [1:0]  r_out_flags;
    logic [7:0]  r_out_type;
    logic [23:0] r_out_size;
    logic [31:0] r_out_time;
    logic [23:0] r_out_stream;
    logic [7:0]  r_out_pbyte;
    logic [15:0] r_out_total, r_out_audio, r_out_video, r_out_script;

    // Result produced by the current byte
    logic        res_valid;
    t_kind       res_kind;
    logic [7:0]  res_pbyte;
    logic        tag_fields;

    logic        in_accept;

    // Hold input only while a result waits and downstream refuses it
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    // Next parse state
    always_comb begin
        t_phase      ph;
        logic [3:0]  pos;
        logic [23:0] rem_dec;

        ph       = r_phase;
        pos      = r_pos;
        n_flags  = r_flags;
        n_remain = r_remain;
        n_type   = r_type;
        n_size   = r_size;
        n_time   = r_time;
        n_stream = r_stream;
        n_total  = r_total;
        n_audio  = r_audio;
        n_video  = r_video;
        n_script = r_script;
        rem_dec  = '0;

        // New file mark: restart parsing and counters in any phase
        if (i_first_byte) begin
            ph       = PH_FILE_HDR;
            pos      = '0;
            n_flags  = '0;
            n_remain = '0;
            n_type   = '0;
            n_size   = '0;
            n_time   = '0;
            n_stream = '0;
            n_total  = '0;
            n_audio  = '0;
            n_video  = '0;
            n_script = '0;
        end

        n_phase   = ph;
        n_pos     = pos;
        res_valid = 1'b0;
        res_kind  = KIND_FILE_HDR;
        res_pbyte = '0;

        case (ph)
            PH_FILE_HDR: begin
                if (pos == FLAGS_POS) begin
                    n_flags = {i_data_byte[2], i_data_byte[0]};
                end
                if (pos >= FILE_HDR_LAST) begin
                    n_phase   = PH_SKIP;
                    n_pos     = '0;
                    res_valid = 1'b1;
                    res_kind  = KIND_FILE_HDR;
                end else begin
                    n_pos = pos + 4'd1;
                end
            end
            PH_SKIP: begin
                if (pos >= SKIP_LAST) begin
                    n_phase = PH_TAG_HDR;
                    n_pos   = '0;
                end else begin
                    n_pos = pos + 4'd1;
                end
            end
            PH_TAG_HDR: begin
                case (pos)
                    4'd0: begin
                        n_type   = i_data_byte;
                        n_size   = '0;
                        n_time   = '0;
                        n_stream = '0;
                    end
                    4'd1, 4'd2, 4'd3: n_size = {n_size[15:0], i_data_byte};
                    4'd4, 4'd5, 4'd6: n_time = {8'd0, n_time[15:0], i_data_byte};
                    4'd7:             n_time = {i_data_byte, n_time[23:0]};
                    default:          n_stream = {n_stream[15:0], i_data_byte};
                endcase
                if (pos >= TAG_HDR_LAST) begin
                    n_pos   = '0;
                    n_total = n_total + 16'd1;
                    if (n_type == TYPE_AUDIO) begin
                        n_audio = n_audio + 16'd1;
                    end else if (n_type == TYPE_VIDEO) begin
                        n_video = n_video + 16'd1;
                    end else if (n_type == TYPE_SCRIPT) begin
                        n_script = n_script + 16'd1;
                    end
                    n_remain  = n_size;
                    n_phase   = (n_size == '0) ? PH_SKIP : PH_PAYLOAD;
                    res_valid = 1'b1;
                    res_kind  = KIND_TAG_HDR;
                end else begin
                    n_pos = pos + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                rem_dec   = (n_remain != '0) ? n_remain - 24'd1 : n_remain;
                n_remain  = rem_dec;
                res_valid = 1'b1;
                res_pbyte = i_data_byte;
                if (rem_dec == '0) begin
                    n_phase  = PH_SKIP;
                    n_pos    = '0;
                    res_kind = KIND_LAST_BYTE;
                end else begin
                    res_kind = KIND_PAYLOAD;
                end
            end
            default: begin
                n_phase = PH_FILE_HDR;
            end
        endcase
    end

    // Tag fields read as zero on the file header record
    always_comb begin
        tag_fields = (res_kind != KIND_FILE_HDR);
    end

    // Advance parse state on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FILE_HDR;
            r_pos    <= '0;
            r_flags  <= '0;
            r_remain <= '0;
            r_type   <= '0;
            r_size   <= '0;
            r_time   <= '0;
            r_stream <= '0;
            r_total  <= '0;
            r_audio  <= '0;
            r_video  <= '0;
            r_script <= '0;
        end else if (in_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_remain <= n_remain;
            r_type   <= n_type;
            r_size   <= n_size;
            r_time   <= n_time;
            r_stream <= n_stream;
            r_total  <= n_total;
            r_audio  <= n_audio;
            r_video  <= n_video;
            r_script <= n_script;
        end
    end

    // Output valid: set on a new result, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load only with a new result, otherwise hold
    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_kind       <= res_kind;
            r_out_flags  <= n_flags;
            r_out_type   <= tag_fields ? n_type   : 8'd0;
            r_out_size   <= tag_fields ? n_size   : 24'd0;
            r_out_time   <= tag_fields ? n_time   : 32'd0;
            r_out_stream <= tag_fields ? n_stream : 24'd0;
            r_out_pbyte  <= res_pbyte;
            r_out_total  <= n_total;
            r_out_audio  <= n_audio;
            r_out_video  <= n_video;
            r_out_script <= n_script;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_has_audio    = r_out_flags[1];
    assign o_has_video    = r_out_flags[0];
    assign o_tag_code     = r_out_type;
    assign o_payload_size = r_out_size;
    assign o_timestamp    = r_out_time;
    assign o_stream_num   = r_out_stream;
    assign o_payload_byte = r_out_pbyte;
    assign o_tag_total    = r_out_total;
    assign o_audio_tags   = r_out_audio;
    assign o_video_tags   = r_out_video;
    assign o_script_tags  = r_out_script;

endmodule
